// File: design/lffs_pkg.sv
// Shared types, register indexes and helpers for the length-field frame splitter.
// No dependencies; every other design file imports this package.
`default_nettype none

package lffs_pkg;

  // Length field offset limit and widths of the frame bookkeeping
  localparam int unsigned MaxLengthOffset = 15;
  localparam int unsigned HdrCountW       = 5;
  localparam int unsigned AccumW          = 32;
  localparam int unsigned PayloadW        = 33;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLengthOffset        = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLengthWidthCode     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLengthBigEndian     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLengthAdjust        = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLengthIncludesHdr   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxFrameBytes       = 3'd5;

  localparam logic [31:0] MaxFrameBytesReset = 32'd65535;

  // Length field size codes
  typedef enum logic [1:0] {
    LenWidth1  = 2'd0,
    LenWidth2  = 2'd1,
    LenWidth4  = 2'd2,
    LenNone    = 2'd3
  } lffs_width_e;

  typedef struct packed {
    logic [3:0]  length_offset;
    lffs_width_e length_width_code;
    logic        length_big_endian;
    logic [15:0] length_adjust;
    logic        length_includes_header;
    logic [31:0] max_frame_bytes;
  } lffs_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       is_header;
    logic       frame_error;
  } lffs_result_t;

  // Number of bytes in the length field
  function automatic logic [2:0] field_bytes(lffs_width_e code);
    logic [2:0] n;
    case (code)
      LenWidth1: n = 3'd1;
      LenWidth2: n = 3'd2;
      LenWidth4: n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // Clamp the length field offset to the supported range
  function automatic logic [3:0] eff_offset(logic [3:0] off);
    logic [3:0] lim;
    lim = 4'(MaxLengthOffset);
    return (off > lim) ? lim : off;
  endfunction

endpackage

`default_nettype wire

// File: design/lffs_cfg.sv
// Configuration register bank of the length-field frame splitter.
// Depends on lffs_pkg for register indexes and the settings struct.
`default_nettype none

module lffs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lffs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lffs_pkg::CfgDataW-1:0] cfg_data_i,
  output lffs_pkg::lffs_cfg_t          cfg_o
);
  import lffs_pkg::*;

  lffs_cfg_t cfg_q, cfg_d;

  // Always take a write beat
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLengthOffset:      cfg_d.length_offset = cfg_data_i[3:0];
        RegLengthWidthCode:   cfg_d.length_width_code = lffs_width_e'(cfg_data_i[1:0]);
        RegLengthBigEndian:   cfg_d.length_big_endian = cfg_data_i[0];
        RegLengthAdjust:      cfg_d.length_adjust = cfg_data_i[15:0];
        RegLengthIncludesHdr: cfg_d.length_includes_header = cfg_data_i[0];
        RegMaxFrameBytes:     cfg_d.max_frame_bytes = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_offset          <= '0;
      cfg_q.length_width_code      <= LenWidth1;
      cfg_q.length_big_endian      <= 1'b0;
      cfg_q.length_adjust          <= '0;
      cfg_q.length_includes_header <= 1'b0;
      cfg_q.max_frame_bytes        <= MaxFrameBytesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/lffs_parse.sv
// Per-byte frame parser: header counting, length field assembly and payload count.
// Depends on lffs_pkg for the settings and result structs.
`default_nettype none

module lffs_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  lffs_pkg::lffs_cfg_t  cfg_i,
  output lffs_pkg::lffs_result_t result_o
);
  import lffs_pkg::*;

  logic                 in_payload_q, in_payload_d;
  logic [HdrCountW-1:0] hdr_count_q, hdr_count_d;
  logic [AccumW-1:0]    accum_q, accum_d;
  logic [PayloadW-1:0]  payload_left_q, payload_left_d;

  logic [3:0]           off;
  logic [2:0]           fbytes;
  logic [4:0]           hl;
  logic [4:0]           hl_eff;
  logic                 in_field;
  logic [1:0]           k;
  logic [4:0]           rel;
  logic [AccumW-1:0]    accum_new;
  logic                 last_hdr;
  logic [PayloadW-1:0]  sum;
  logic [PayloadW-1:0]  hl_ext;
  logic [PayloadW-1:0]  plen;
  logic [PayloadW:0]    total;
  logic                 under;
  logic                 oversize;
  logic                 len_nz;

  // Header geometry from the current settings
  always_comb begin
    off    = eff_offset(cfg_i.length_offset);
    fbytes = field_bytes(cfg_i.length_width_code);
    hl     = {1'b0, off} + {2'b00, fbytes};
    hl_eff = (hl == 5'd0) ? 5'd1 : hl;
    hl_ext = PayloadW'(hl);
  end

  // Gather the length field byte
  always_comb begin
    in_field = (hdr_count_q >= {1'b0, off}) && (hdr_count_q < hl);
    rel      = hdr_count_q - {1'b0, off};
    k        = rel[1:0];
    accum_new = accum_q;
    if (in_field) begin
      if (cfg_i.length_big_endian) begin
        accum_new = {accum_q[AccumW-9:0], byte_i};
      end else begin
        accum_new = accum_q | ({{(AccumW-8){1'b0}}, byte_i} << {k, 3'b000});
      end
    end
    last_hdr = ({1'b0, hdr_count_q} + 6'd1) >= {1'b0, hl_eff};
  end

  // Length checks at the last header byte
  always_comb begin
    len_nz   = (accum_new != '0);
    sum      = {1'b0, accum_new} + PayloadW'(cfg_i.length_adjust);
    under    = cfg_i.length_includes_header && (sum < hl_ext);
    plen     = cfg_i.length_includes_header ? (sum - hl_ext) : sum;
    total    = cfg_i.length_includes_header ? {1'b0, sum} : ({1'b0, sum} + {1'b0, hl_ext});
    oversize = total > {2'b00, cfg_i.max_frame_bytes};
  end

  // Next state and result for this byte
  always_comb begin
    in_payload_d   = in_payload_q;
    hdr_count_d    = hdr_count_q;
    accum_d        = accum_q;
    payload_left_d = payload_left_q;
    result_o.out_byte    = byte_i;
    result_o.frame_start = 1'b0;
    result_o.frame_end   = 1'b0;
    result_o.is_header   = 1'b0;
    result_o.frame_error = 1'b0;
    if (in_payload_q) begin
      if (payload_left_q <= PayloadW'(1)) begin
        result_o.frame_end = 1'b1;
        in_payload_d   = 1'b0;
        payload_left_d = '0;
      end else begin
        payload_left_d = payload_left_q - PayloadW'(1);
      end
    end else begin
      result_o.is_header   = 1'b1;
      result_o.frame_start = (hdr_count_q == '0);
      if (last_hdr) begin
        hdr_count_d = '0;
        accum_d     = '0;
        if (len_nz && !under && !oversize && (plen != '0)) begin
          in_payload_d   = 1'b1;
          payload_left_d = plen;
        end else begin
          result_o.frame_end   = 1'b1;
          result_o.frame_error = len_nz && (under || oversize);
        end
      end else begin
        hdr_count_d = hdr_count_q + HdrCountW'(1);
        accum_d     = accum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      hdr_count_q    <= '0;
      accum_q        <= '0;
      payload_left_q <= '0;
    end else if (step_i) begin
      in_payload_q   <= in_payload_d;
      hdr_count_q    <= hdr_count_d;
      accum_q        <= accum_d;
      payload_left_q <= payload_left_d;
    end
  end

`ifndef SYNTHESIS
  // Header bookkeeping is clear while counting payload
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (hdr_count_q == '0) && (accum_q == '0))
    else $error("header state not clear in payload phase");

  // Payload phase always has bytes still due
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (payload_left_q != '0))
    else $error("payload phase with zero count");

  // Leave payload phase only on the counted last byte
  a_payload_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && in_payload_q && (payload_left_q > PayloadW'(1))) |=> in_payload_q)
    else $error("payload phase left early");
`endif

endmodule

`default_nettype wire

// File: design/length_field_frame_splitter_core.sv
// Top level of the length-field frame splitter: input stage, parser, result stage.
// Depends on lffs_pkg, lffs_cfg and lffs_parse.
// An accepted byte passes the input register, then the result register, and is held there
// while out_stall_i is high.
// Throughput: one byte per cycle while the output does not stall; the parser state updates
// once per byte as it leaves the input register for the result register.
// Reset (rst_ni low, asynchronous): stages empty, parser in header phase, registers
// back to defaults (max_frame_bytes 65535, others zero).
`default_nettype none

module length_field_frame_splitter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          frame_start_o,
  output logic                          frame_end_o,
  output logic                          is_header_o,
  output logic                          frame_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lffs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lffs_pkg::CfgDataW-1:0] cfg_data_i
);
  import lffs_pkg::*;

  lffs_cfg_t    cfg;
  lffs_result_t result;
  lffs_result_t out_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  logic         advance;
  logic         in_take;

  lffs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move a beat from the input stage when the result stage frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  lffs_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Result stage: load on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.out_byte;
  assign frame_start_o = out_q.frame_start;
  assign frame_end_o   = out_q.frame_end;
  assign is_header_o   = out_q.is_header;
  assign frame_error_o = out_q.frame_error;

`ifndef SYNTHESIS
  // Input stalls only while its stage holds a beat
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked beat");

  // An error mark closes the frame on a header byte
  a_error_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_error_o) |-> (frame_end_o && is_header_o))
    else $error("error mark off the last header byte");

  // A frame opens on a header byte
  a_start_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_start_o) |-> is_header_o)
    else $error("frame start on a payload byte");
`endif

endmodule

`default_nettype wire

// File: dv/length_field_frame_splitter_core_test.sv
// Self-checking testbench for length_field_frame_splitter_core: random and directed
// byte streams under several register settings, each beat checked against a predictor.
// Depends on lffs_pkg and the design files of the splitter.
`timescale 1ns / 1ps

module length_field_frame_splitter_core_test;
  import lffs_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 250;

  // Block ports
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          in_byte_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                frame_start_o;
  logic                frame_end_o;
  logic                is_header_o;
  logic                frame_error_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Stimulus, expectations and bookkeeping
  byte_q_t             pending_bytes;
  lffs_result_t        expected_beats[$];
  int unsigned         error_count    = 0;
  int unsigned         bytes_checked  = 0;
  int unsigned         frames_closed  = 0;
  int unsigned         error_frames   = 0;
  int unsigned         settings_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         idle_pct       = 25;
  int unsigned         stall_pct      = 25;
  int unsigned         gap_left       = 0;
  int unsigned         stall_left     = 0;
  int unsigned         hold_left      = 0;
  logic                stall_now;
  logic                hold_kick      = 1'b0;
  logic                hold_done      = 1'b0;

  // Predictor copy of the registers and of the parser state
  lffs_cfg_t           settings;
  logic                in_payload;
  logic [4:0]          hdr_count;
  logic [31:0]         len_accum;
  logic [32:0]         payload_left;

  length_field_frame_splitter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .is_header_o   (is_header_o),
    .frame_error_o (frame_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned field_size(lffs_width_e code);
    case (code)
      LenWidth1: return 1;
      LenWidth2: return 2;
      LenWidth4: return 4;
      default:   return 0;
    endcase
  endfunction

  function automatic lffs_cfg_t make_settings(logic [3:0] off, lffs_width_e code, logic be,
                                              logic [15:0] adj, logic incl,
                                              logic [31:0] max_bytes);
    lffs_cfg_t c;
    c.length_offset          = off;
    c.length_width_code      = code;
    c.length_big_endian      = be;
    c.length_adjust          = adj;
    c.length_includes_header = incl;
    c.max_frame_bytes        = max_bytes;
    return c;
  endfunction

  function automatic lffs_cfg_t rand_settings();
    lffs_cfg_t c;
    c.length_offset = ($urandom_range(3) == 0) ? 4'($urandom_range(7, 15))
                                               : 4'($urandom_range(0, 6));
    c.length_width_code      = lffs_width_e'($urandom_range(0, 3));
    c.length_big_endian      = 1'($urandom_range(1));
    c.length_adjust          = ($urandom_range(4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 3));
    c.length_includes_header = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       c.max_frame_bytes = $urandom_range(0, 40);
      1:       c.max_frame_bytes = MaxFrameBytesReset;
      2:       c.max_frame_bytes = 32'hFFFF_FFFF;
      default: c.max_frame_bytes = $urandom;
    endcase
    // A large adjust must meet a small limit, or one frame would swallow the stream
    if (c.length_adjust > 16'd64) c.max_frame_bytes = $urandom_range(0, 80);
    return c;
  endfunction

  // Build well-formed frames for the given settings, with some stray bytes mixed in
  function automatic byte_q_t make_stream(lffs_cfg_t c, int unsigned n);
    byte_q_t     s;
    int unsigned off, w, h, pay, k, sh;
    longint      vv, v, len, fmax;
    off  = c.length_offset;
    w    = field_size(c.length_width_code);
    h    = off + w;
    fmax = (w == 4) ? 64'hFFFF_FFFF : (64'd1 << (8 * w)) - 1;
    while (s.size() < n) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
      end else begin
        pay = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        vv  = longint'(pay) - longint'(c.length_adjust)
            + (c.length_includes_header ? longint'(h) : 0);
        if (w == 0 || (pay == 0 && $urandom_range(1) == 0)) v = 0;
        else if (vv >= 1 && vv <= fmax) v = vv;
        else v = $urandom_range(1, 60);
        for (int i = 0; i < ((h == 0) ? 1 : h); i++) begin
          if (i < off || w == 0) begin
            s.push_back(8'($urandom));
          end else begin
            k  = i - off;
            sh = c.length_big_endian ? (w - 1 - k) : k;
            s.push_back(8'(v >> (8 * sh)));
          end
        end
        // Payload follows only when the frame is accepted
        len = (v == 0) ? 0 : v + c.length_adjust;
        if (c.length_includes_header) len = (len < h) ? 0 : len - h;
        if (len > 0 && len + h <= c.max_frame_bytes && len <= 100)
          repeat (len) s.push_back(8'($urandom));
      end
    end
    return s;
  endfunction

  task automatic start_new_frame();
    in_payload   = 1'b0;
    hdr_count    = '0;
    len_accum    = '0;
    payload_left = '0;
  endtask

  // Work out the marks for one accepted byte and queue them
  task automatic predict_beat(input logic [7:0] b);
    lffs_result_t r;
    int unsigned  off, w, hl;
    logic [63:0]  len, h;
    r          = '0;
    r.out_byte = b;
    if (in_payload) begin
      if (payload_left <= 33'd1) begin
        r.frame_end = 1'b1;
        start_new_frame();
      end else begin
        payload_left = payload_left - 33'd1;
      end
    end else begin
      // Offset is 4 bits wide, so it never exceeds the limit of 15
      off = settings.length_offset;
      w   = field_size(settings.length_width_code);
      hl  = (off + w == 0) ? 1 : off + w;
      r.is_header   = 1'b1;
      r.frame_start = (hdr_count == 0);
      if (hdr_count >= off && hdr_count < off + w) begin
        if (settings.length_big_endian) len_accum = {len_accum[23:0], b};
        else len_accum = len_accum | (32'(b) << (8 * ((hdr_count - off) & 3)));
      end
      if (hdr_count + 1 >= hl) begin
        len         = 64'(len_accum);
        h           = 64'(off + w);
        r.frame_end = 1'b1;
        if (len != 0) begin
          len = len + 64'(settings.length_adjust);
          if (settings.length_includes_header) begin
            if (len < h) begin
              r.frame_error = 1'b1;
              len           = 0;
            end else begin
              len = len - h;
            end
          end
          if (!r.frame_error && len + h > 64'(settings.max_frame_bytes)) r.frame_error = 1'b1;
          if (!r.frame_error && len != 0) begin
            r.frame_end  = 1'b0;
            in_payload   = 1'b1;
            hdr_count    = '0;
            len_accum    = '0;
            payload_left = len[32:0];
          end
        end
        if (r.frame_end) start_new_frame();
      end else begin
        hdr_count = hdr_count + 5'd1;
      end
    end
    expected_beats.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_beat();
    lffs_result_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: unexpected beat, actual byte %0h", $time, out_byte_o);
      error_count++;
    end else begin
      want = expected_beats.pop_front();
      check_field("out_byte", want.out_byte, out_byte_o);
      check_field("frame_start", 8'(want.frame_start), 8'(frame_start_o));
      check_field("frame_end", 8'(want.frame_end), 8'(frame_end_o));
      check_field("is_header", 8'(want.is_header), 8'(is_header_o));
      check_field("frame_error", 8'(want.frame_error), 8'(frame_error_o));
      bytes_checked++;
      if (frame_end_o) frames_closed++;
      if (frame_error_o) error_frames++;
    end
  endtask

  // Write every register; valid stays high across back-to-back writes
  task automatic program_regs(input lffs_cfg_t c);
    logic [CfgIdxW-1:0]  reg_idx [6];
    logic [CfgDataW-1:0] word    [6];
    reg_idx[0] = RegLengthOffset;      word[0] = 32'(c.length_offset);
    reg_idx[1] = RegLengthWidthCode;   word[1] = 32'(c.length_width_code);
    reg_idx[2] = RegLengthBigEndian;   word[2] = 32'(c.length_big_endian);
    reg_idx[3] = RegLengthAdjust;      word[3] = 32'(c.length_adjust);
    reg_idx[4] = RegLengthIncludesHdr; word[4] = 32'(c.length_includes_header);
    reg_idx[5] = RegMaxFrameBytes;     word[5] = c.max_frame_bytes;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i  <= word[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings = c;
    settings_count++;
  endtask

  // Program, load the stream and wait until every byte has come back
  task automatic run_phase(input lffs_cfg_t c, input byte_q_t seq, input logic with_hold);
    program_regs(c);
    @(negedge clk_i);
    hold_kick = with_hold;
    foreach (seq[i]) pending_bytes.push_back(seq[i]);
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_beats.size() != 0);
  endtask

  // Input driver: offer queued bytes, predict each accepted beat, idle in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= '0;
      gap_left    = 0;
      start_new_frame();
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_beat(in_byte_i);
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0 && idle_pct != 0 &&
                   $urandom_range(99) < idle_pct) begin
        gap_left    = $urandom_range(0, 8);
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_byte_i  <= pending_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: check accepted beats, stall in bursts or during the long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_beat();
      if (stall_left != 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 8);
        stall_now  = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      out_stall_i <= stall_now || (hold_left != 0);
    end
  end

  // Long receiver hold-off, taken once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_kick && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    byte_q_t   seq;
    lffs_cfg_t c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: zero length, two-byte payload, one-byte payload
    c   = make_settings(4'd0, LenWidth1, 1'b0, 16'd0, 1'b0, MaxFrameBytesReset);
    seq = '{8'h00, 8'h02, 8'hAA, 8'h55, 8'h01, 8'hFF};
    run_phase(c, seq, 1'b0);

    // No header at all: every byte is a frame of its own
    c   = make_settings(4'd0, LenNone, 1'b0, 16'd0, 1'b0, MaxFrameBytesReset);
    seq = '{8'h00, 8'hFF};
    run_phase(c, seq, 1'b0);

    // Length counting the header: too short, zero payload left, oversized
    c   = make_settings(4'd1, LenWidth2, 1'b1, 16'd0, 1'b1, 32'd8);
    seq = '{8'h33, 8'h00, 8'h02, 8'h5A, 8'h00, 8'h03, 8'hA5, 8'h00, 8'h20};
    run_phase(c, seq, 1'b0);

    // Widest field and adjust: the total passes even the largest limit
    c   = make_settings(4'd0, LenWidth4, 1'b0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    run_phase(c, seq, 1'b0);

    // Random frames under extreme and random settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       c = make_settings(4'd15, LenWidth4, 1'b1, 16'd0, 1'b1, 32'hFFFF_FFFF);
        1:       c = make_settings(4'd3, LenWidth2, 1'b1, 16'hFFFF, 1'b0, 32'd0);
        2:       c = make_settings(4'd0, LenNone, 1'b0, 16'd0, 1'b0, MaxFrameBytesReset);
        default: c = rand_settings();
      endcase
      idle_pct  = (p == 3 || p == 7) ? 0 : 25;
      stall_pct = (p == 3 || p == 7) ? 0 : 25;
      seq       = make_stream(c, 110);
      run_phase(c, seq, p == 4);
    end

    repeat (8) @(posedge clk_i);
    $display("Checked %0d bytes under %0d register settings", bytes_checked, settings_count);
    $display("Frames closed: %0d, flagged with errors: %0d", frames_closed, error_frames);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
